@@ rtl/ntc_table_interpolation_macros.svh @@
// assertion macros used by the checker file
`ifndef NTC_TABLE_INTERPOLATION_MACROS_SVH
`define NTC_TABLE_INTERPOLATION_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define NTC_TI_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NTC_TI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ntc_ti_pkg.sv @@
package ntc_ti_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int MIN_ENTRIES = 2;

	localparam int X_W = 13;
	localparam int Y_W = 19;
	localparam int WORD_W = X_W + Y_W;
	localparam int IDX_W = 6;
	localparam int TEMP_W = 16;
	localparam int SLOPE_W = 16;
	localparam int FRAC_BITS = 9;
	localparam int HALF_LSB = 512 / 2;
	localparam int RES_W = TEMP_W + FRAC_BITS;
	localparam int DIFF_W = X_W + 1;
	localparam int DIV_CNT_W = $clog2(SLOPE_W + 1);

	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd64;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ENTRIES_IN_USE = 1'b0;

	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic             operation;
		logic [X_W-1:0]   sample_sum;
		logic [IDX_W-1:0] entry_index;
		logic [X_W-1:0]   entry_x;
		logic [Y_W-1:0]   entry_y;
	} item_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature;
		logic              exact_hit;
		logic              range_error;
	} result_t;

	typedef enum logic {
		CMD_CONVERT,
		CMD_LOAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [X_W-1:0]    sample;
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] word;
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_ADDR,
		BK_CMP,
		BK_FIX,
		BK_RDLO,
		BK_RDHI,
		BK_DIV,
		BK_MUL,
		BK_SUM,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic               start;
		logic [SLOPE_W-1:0] dividend;
		logic [X_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [SLOPE_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/ntc_ti_ram.sv @@
module ntc_ti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/ntc_ti_front.sv @@
module ntc_ti_front #(
	parameter int TABLE_ENTRIES = ntc_ti_pkg::TABLE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  ntc_ti_pkg::item_t item,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output ntc_ti_pkg::cmd_t  cmd
);

	localparam int QD = ntc_ti_pkg::QUEUE_DEPTH;
	localparam logic [ntc_ti_pkg::QPTR_W-1:0] PTR_LAST = ntc_ti_pkg::QPTR_W'(QD - 1);
	localparam logic [ntc_ti_pkg::QCNT_W-1:0] CNT_FULL = ntc_ti_pkg::QCNT_W'(QD);

	ntc_ti_pkg::cmd_t                 queue_q [QD];
	logic [ntc_ti_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [ntc_ti_pkg::QCNT_W-1:0]    cnt_q;
	ntc_ti_pkg::cmd_t                 cmd_in;
	logic                             drop, push, pop;

	// loads past the end of the table are taken and thrown away here
	always_comb begin
		cmd_in.kind   = (item.operation == ntc_ti_pkg::OP_LOAD) ?
			ntc_ti_pkg::CMD_LOAD : ntc_ti_pkg::CMD_CONVERT;
		cmd_in.sample = item.sample_sum;
		cmd_in.index  = item.entry_index;
		cmd_in.word   = {item.entry_y, item.entry_x};
		drop = (item.operation == ntc_ti_pkg::OP_LOAD) &&
			(32'(item.entry_index) >= TABLE_ENTRIES);
	end

	assign item_ready = (cnt_q != CNT_FULL);
	assign push       = item_valid && item_ready && !drop;
	assign pop        = cmd_pop && cmd_valid;
	assign cmd_valid  = (cnt_q != '0);
	assign cmd        = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

@@ rtl/ntc_ti_div.sv @@
module ntc_ti_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ntc_ti_pkg::div_req_t req,
	output ntc_ti_pkg::div_rsp_t rsp
);

	localparam int QW = ntc_ti_pkg::SLOPE_W;
	localparam int DW = ntc_ti_pkg::X_W;
	localparam logic [ntc_ti_pkg::DIV_CNT_W-1:0] STEPS = ntc_ti_pkg::DIV_CNT_W'(QW);

	logic                               busy_q, done_q;
	logic [ntc_ti_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [DW-1:0]                      rem_q, dsor_q;
	logic [QW-1:0]                      quo_q;
	logic [DW:0]                        trial;
	logic                               take;

	// restoring divide, one quotient bit a cycle
	assign trial = {rem_q, quo_q[QW-1]};
	assign take  = (trial >= {1'b0, dsor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ntc_ti_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dsor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? DW'(trial - {1'b0, dsor_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/ntc_ti_back.sv @@
module ntc_ti_back #(
	parameter int TABLE_ENTRIES = ntc_ti_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ntc_ti_pkg::CFG_W-1:0]      entries_in_use,
	input  logic                              cmd_valid,
	input  ntc_ti_pkg::cmd_t                  cmd,
	output logic                              cmd_pop,
	output logic                              result_valid,
	input  logic                              result_ready,
	output ntc_ti_pkg::result_t               result
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int XW = ntc_ti_pkg::X_W;
	localparam int YW = ntc_ti_pkg::Y_W;
	localparam int SW = ntc_ti_pkg::SLOPE_W;
	localparam int RW = ntc_ti_pkg::RES_W;
	localparam int FB = ntc_ti_pkg::FRAC_BITS;
	localparam int PW = ntc_ti_pkg::DIFF_W + SW + 1;
	localparam logic [AW-1:0] LAST_MAX = AW'(TABLE_ENTRIES - 1);
	localparam logic [AW-1:0] LAST_MIN = AW'(ntc_ti_pkg::MIN_ENTRIES - 1);

	ntc_ti_pkg::back_state_t state_q, state_d;

	logic [AW-1:0]          lo_q, hi_q, mid_q, last_q;
	logic [XW-1:0]          sample_q, lx_q, nx_q;
	logic [YW-1:0]          ly_q;
	logic                   neg_q;
	logic [SW-1:0]          slope_q;
	logic [RW-1:0]          prod_q;
	ntc_ti_pkg::result_t    res_q, out_q;
	logic                   out_valid_q;

	logic [AW-1:0]          last, mid, new_lo, new_hi, fix_hi, raddr;
	logic [AW:0]            mid_sum;
	logic [ntc_ti_pkg::WORD_W-1:0] rdata;
	logic [XW-1:0]          rd_x;
	logic [YW-1:0]          rd_y;
	logic                   hit, below, ram_we, load_out;
	logic [XW:0]            gap, gap_neg, diff;
	logic [XW-1:0]          gap_mag;
	logic [YW:0]            exact_sum;
	logic signed [PW-1:0]   prod_full;
	logic [RW-1:0]          res_sum;
	logic [SW-1:0]          div_q;
	ntc_ti_pkg::div_req_t   div_req;
	ntc_ti_pkg::div_rsp_t   div_rsp;

	ntc_ti_ram #(
		.WIDTH (ntc_ti_pkg::WORD_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.index)),
		.wdata (cmd.word),
		.raddr (raddr),
		.rdata (rdata)
	);

	ntc_ti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// last usable index, count clamped to between MIN_ENTRIES and the table size
	always_comb begin
		if (entries_in_use < ntc_ti_pkg::CFG_W'(ntc_ti_pkg::MIN_ENTRIES)) begin
			last = LAST_MIN;
		end else if (32'(entries_in_use) > TABLE_ENTRIES) begin
			last = LAST_MAX;
		end else begin
			last = AW'(entries_in_use - 1'b1);
		end
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (AW+1)'(1);
	assign mid     = mid_sum[AW:1];
	assign rd_x    = rdata[XW-1:0];
	assign rd_y    = rdata[ntc_ti_pkg::WORD_W-1:XW];
	assign hit     = (rd_x == sample_q);
	assign below   = (sample_q < rd_x);
	assign new_lo  = below ? lo_q : mid_q;
	assign new_hi  = below ? mid_q - 1'b1 : hi_q;
	// a search that ends on the last entry falls back one pair
	assign fix_hi  = (hi_q == last_q) ? hi_q - 1'b1 : hi_q;

	assign gap       = {1'b0, rd_x} - {1'b0, lx_q};
	assign gap_neg   = '0 - gap;
	assign gap_mag   = gap[XW] ? gap_neg[XW-1:0] : gap[XW-1:0];
	assign diff      = {1'b0, sample_q} - {1'b0, lx_q};
	assign prod_full = $signed(diff) * $signed({1'b0, slope_q});
	assign res_sum   = RW'(ly_q) - prod_q + RW'(ntc_ti_pkg::HALF_LSB);
	assign exact_sum = {1'b0, rd_y} + (YW+1)'(ntc_ti_pkg::HALF_LSB);
	assign div_q     = div_rsp.quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntc_ti_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		raddr            = mid;
		ram_we           = 1'b0;
		cmd_pop          = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = ly_q[SW-1:0] - rd_y[SW-1:0];
		div_req.divisor  = gap_mag;
		case (state_q)
			ntc_ti_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.kind == ntc_ti_pkg::CMD_LOAD) begin
						ram_we = 1'b1;
					end else begin
						state_d = ntc_ti_pkg::BK_ADDR;
					end
				end
			end
			ntc_ti_pkg::BK_ADDR: begin
				state_d = ntc_ti_pkg::BK_CMP;
			end
			ntc_ti_pkg::BK_CMP: begin
				if (hit) begin
					state_d = ntc_ti_pkg::BK_DONE;
				end else if (new_hi <= new_lo) begin
					state_d = ntc_ti_pkg::BK_FIX;
				end else begin
					state_d = ntc_ti_pkg::BK_ADDR;
				end
			end
			ntc_ti_pkg::BK_FIX: begin
				raddr   = fix_hi;
				state_d = ntc_ti_pkg::BK_RDLO;
			end
			ntc_ti_pkg::BK_RDLO: begin
				raddr   = hi_q + 1'b1;
				state_d = ntc_ti_pkg::BK_RDHI;
			end
			ntc_ti_pkg::BK_RDHI: begin
				if (gap == '0) begin
					state_d = ntc_ti_pkg::BK_MUL;
				end else begin
					div_req.start = 1'b1;
					state_d       = ntc_ti_pkg::BK_DIV;
				end
			end
			ntc_ti_pkg::BK_DIV: begin
				if (div_rsp.done) begin
					state_d = ntc_ti_pkg::BK_MUL;
				end
			end
			ntc_ti_pkg::BK_MUL: begin
				state_d = ntc_ti_pkg::BK_SUM;
			end
			ntc_ti_pkg::BK_SUM: begin
				state_d = ntc_ti_pkg::BK_DONE;
			end
			ntc_ti_pkg::BK_DONE: begin
				if (!out_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = ntc_ti_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = ntc_ti_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ntc_ti_pkg::BK_IDLE: begin
				lo_q     <= '0;
				hi_q     <= last;
				last_q   <= last;
				sample_q <= cmd.sample;
			end
			ntc_ti_pkg::BK_ADDR: begin
				mid_q <= mid;
			end
			ntc_ti_pkg::BK_CMP: begin
				if (hit) begin
					res_q.temperature <= ntc_ti_pkg::TEMP_W'(exact_sum[YW:FB]);
					res_q.exact_hit   <= 1'b1;
					res_q.range_error <= 1'b0;
				end else begin
					lo_q <= new_lo;
					hi_q <= new_hi;
				end
			end
			ntc_ti_pkg::BK_FIX: begin
				hi_q <= fix_hi;
			end
			ntc_ti_pkg::BK_RDLO: begin
				lx_q <= rd_x;
				ly_q <= rd_y;
			end
			ntc_ti_pkg::BK_RDHI: begin
				nx_q    <= rd_x;
				neg_q   <= gap[XW];
				slope_q <= '1;
			end
			ntc_ti_pkg::BK_DIV: begin
				if (div_rsp.done) begin
					slope_q <= neg_q ? '0 - div_q : div_q;
				end
			end
			ntc_ti_pkg::BK_MUL: begin
				prod_q <= prod_full[RW-1:0];
			end
			ntc_ti_pkg::BK_SUM: begin
				res_q.temperature <= res_sum[RW-1:FB];
				res_q.exact_hit   <= 1'b0;
				res_q.range_error <= (lx_q > sample_q) || (sample_q > nx_q);
			end
			default: begin
			end
		endcase
	end

	// output register, frees the sequencer while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ rtl/ntc_table_interpolation.sv @@
// channel   dir  handshake                        beat
// item      in   item_valid / item_ready          convert or table load
// result    out  result_valid / result_ready      one per convert
// config    in   psel penable pwrite, pready = 1  entries_in_use at 0x0
//
// a load beat is written to the table straight from the idle state; a convert (n = entries in use)
// runs a binary search, each probe an address and a compare step on the registered table port,
// then the serial slope divide, multiply, sum and hand-off
// a two-entry queue lets item beats land while the sequencer or result side stalls
// arst_n clears the queue, sequencer and result valid; table contents are not reset
module ntc_table_interpolation #(
	parameter int TABLE_ENTRIES = ntc_ti_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  ntc_ti_pkg::item_t               item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output ntc_ti_pkg::result_t             result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ntc_ti_pkg::PADDR_W-1:0]  paddr,
	input  logic [ntc_ti_pkg::PDATA_W-1:0]  pwdata,
	output logic [ntc_ti_pkg::PDATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int RI = ntc_ti_pkg::PADDR_W - 1;

	logic [ntc_ti_pkg::CFG_W-1:0] entries_q;
	logic                         cmd_valid, cmd_pop;
	ntc_ti_pkg::cmd_t             cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[RI] == ntc_ti_pkg::REG_ENTRIES_IN_USE) ?
		ntc_ti_pkg::PDATA_W'(entries_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ntc_ti_pkg::ENTRIES_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[RI] == ntc_ti_pkg::REG_ENTRIES_IN_USE) begin
			entries_q <= pwdata[ntc_ti_pkg::CFG_W-1:0];
		end
	end

	ntc_ti_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	ntc_ti_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.entries_in_use (entries_q),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result)
	);

endmodule

@@ rtl/ntc_ti_checker.sv @@
`include "ntc_table_interpolation_macros.svh"

module ntc_ti_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            result_valid,
	input logic                            result_ready,
	input ntc_ti_pkg::result_t             result,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [ntc_ti_pkg::PADDR_W-1:0]  paddr,
	input logic [ntc_ti_pkg::PDATA_W-1:0]  pwdata,
	input logic [ntc_ti_pkg::PDATA_W-1:0]  prdata,
	input logic                            pready
);

	localparam int RI = ntc_ti_pkg::PADDR_W - 1;
	localparam int CW = ntc_ti_pkg::CFG_W;

	logic cfg_sel, cfg_wr;

	assign cfg_sel = (paddr[RI] == ntc_ti_pkg::REG_ENTRIES_IN_USE);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

	// a stalled result beat holds
	`NTC_TI_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

	// an exact hit never reports a bracket error
	`NTC_TI_ASSERT_IMPL(a_hit_no_error, result_valid && result.exact_hit, !result.range_error, "exact hit with range error")

	// a rounded 19-bit breakpoint never exceeds 1024 tenths
	`NTC_TI_ASSERT_IMPL(a_hit_bound, result_valid && result.exact_hit, result.temperature <= 16'd1024, "exact hit temperature out of bound")

	// a register write is visible on the next read
	`NTC_TI_ASSERT_IMPL(a_cfg_readback, cfg_wr ##1 cfg_sel, prdata == ntc_ti_pkg::PDATA_W'($past(pwdata[CW-1:0])), "entries_in_use readback mismatch")

endmodule

bind ntc_table_interpolation ntc_ti_checker u_ntc_ti_checker (.*);
